### rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds the request and response transfer layouts and the operation codes.
// No dependencies.

package bba_pkg;

   localparam int BLOCK_W     = 13;
   localparam int COUNT_W     = 14;
   localparam int TOTAL_RESET = 8192;

   localparam logic [COUNT_W-1:0] USED_MAX = 14'h3FFF;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_TEST  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BLOCK_W-1:0] block_number;
      logic               bit_value;
   } req_payload_type;

   typedef struct packed {
      logic               status;
      logic [BLOCK_W-1:0] result_block;
      logic               bit_read;
      logic [COUNT_W-1:0] free_count;
   } rsp_payload_type;

endpackage

### rtl/bba_map_ram.sv
// Occupancy map storage: one write port and one registered read port.
// Stand-alone; no package needed.

module bba_map_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/bba_scan_unit.sv
// Find-first-free unit: picks the lowest clear bit of one map word among the valid bits.
// Stand-alone; no package needed.

module bba_scan_unit #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         word,
   input  logic [WIDTH-1:0]         valid_mask,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] index,
   output logic [WIDTH-1:0]         onehot
);

   localparam int IW = $clog2(WIDTH);

   logic [WIDTH-1:0] free_bits;

   // Isolating the lowest set bit with x & -x keeps this to a single carry chain.
   assign free_bits = ~word & valid_mask;
   assign onehot    = free_bits & (~free_bits + WIDTH'(1));
   assign found     = |free_bits;

   // Encode the one-hot position; each index bit is an independent OR reduction.
   always_comb begin
      index = '0;
      for (int k = 0; k < IW; k++) begin
         for (int j = 0; j < WIDTH; j++) begin
            if (((j >> k) & 1) == 1) begin
               index[k] = index[k] | onehot[j];
            end
         end
      end
   end

endmodule

### rtl/bitmap_block_allocator_core.sv
// Bitmap first-fit block allocator: one occupancy bit per block plus a used-block count.
// Depends on bba_pkg, bba_map_ram and bba_scan_unit.
//
// The map is held in a RAM of MAP_BITS/SCAN_WIDTH words with one read port and one write
// port, and one find-first-free unit inspects one word per clock. Allocate reads map words in
// turn until a free block is found or the scan gives up, after at most MAP_BITS/SCAN_WIDTH
// words; the result then passes through the respond state into the output register. Free
// and write are a read-modify-write of one map word; test only reads that word. After reset
// the map is cleared by a pass that writes one word per cycle over all MAP_BITS/SCAN_WIDTH
// words; req_ready stays low during that pass, whilst writes to total_blocks are taken as
// usual. The response sits in an output register, so a finished result may wait for
// rsp_ready while the block takes the next request. total_blocks should only be written
// while the block is idle. MAP_BITS and SCAN_WIDTH must be powers of two with MAP_BITS at
// least twice SCAN_WIDTH.

module bitmap_block_allocator_core
   import bba_pkg::*;
#(
   parameter int MAP_BITS   = 8192,
   parameter int SCAN_WIDTH = 64
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,

   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data
);

   localparam int LOG_SW    = $clog2(SCAN_WIDTH);
   localparam int IDX_W     = $clog2(MAP_BITS);
   localparam int ROWS      = MAP_BITS / SCAN_WIDTH;
   localparam int ROW_W     = IDX_W - LOG_SW;
   localparam int CNT_W     = IDX_W + 1;
   localparam int WIDE_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int EXT_W     = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
   localparam int CMP_W     = EXT_W + 1;
   localparam int EFF_RESET = (TOTAL_RESET > MAP_BITS) ? MAP_BITS : TOTAL_RESET;

   // One-hot sequencer.
   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_MODIFY  = 5'b01000,
      ST_RESPOND = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   op_type                op_ff, op_in;
   logic [BLOCK_W-1:0]    blk_ff, blk_in;
   logic                  val_ff, val_in;
   logic [COUNT_W-1:0]    used_ff, used_in;
   logic [COUNT_W-1:0]    eff_ff, eff_in;
   logic                  res_status_ff, res_status_in;
   logic [BLOCK_W-1:0]    res_block_ff, res_block_in;
   logic                  res_bit_ff, res_bit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   // Map RAM ports.
   logic                  mem_wr_en;
   logic [ROW_W-1:0]      mem_wr_addr;
   logic [SCAN_WIDTH-1:0] mem_wr_data;
   logic [ROW_W-1:0]      mem_rd_addr;
   logic [SCAN_WIDTH-1:0] mem_rd_data;

   // Scan unit.
   logic [SCAN_WIDTH-1:0] valid_mask;
   logic                  scan_found;
   logic [LOG_SW-1:0]     scan_index;
   logic [SCAN_WIDTH-1:0] scan_onehot;

   // Derived values.
   logic [WIDE_W-1:0]     eff_wide;
   logic [WIDE_W-1:0]     eff_row;
   logic [LOG_SW-1:0]     eff_lo;
   logic                  row_lt;
   logic                  row_eq;
   logic [ROW_W:0]        next_row;
   logic                  more_rows;
   logic [EXT_W-1:0]      req_ext;
   logic [EXT_W-1:0]      blk_ext;
   logic [LOG_SW-1:0]     blk_pos;
   logic                  blk_in_map;
   logic [SCAN_WIDTH-1:0] blk_bit;
   logic [IDX_W-1:0]      found_block;
   logic [COUNT_W-1:0]    free_count;
   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  rsp_slot_free;

   bba_map_ram #(
      .DEPTH (ROWS),
      .WIDTH (SCAN_WIDTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bba_scan_unit #(
      .WIDTH (SCAN_WIDTH)
   ) u_scan_unit (
      .word       (mem_rd_data),
      .valid_mask (valid_mask),
      .found      (scan_found),
      .index      (scan_index),
      .onehot     (scan_onehot)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_payload_ff;
   assign rsp_xfer      = rsp_valid_ff && rsp_ready;
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // Only blocks below the effective total may be handed out. The word holding the limit is
   // partly valid; words below it are wholly valid.
   assign eff_wide = WIDE_W'(eff_ff);
   assign eff_row  = eff_wide >> LOG_SW;
   assign eff_lo   = eff_wide[LOG_SW-1:0];
   assign row_lt   = WIDE_W'(row_ff) < eff_row;
   assign row_eq   = WIDE_W'(row_ff) == eff_row;

   always_comb begin
      for (int j = 0; j < SCAN_WIDTH; j++) begin
         valid_mask[j] = row_lt || (row_eq && (LOG_SW'(j) < eff_lo));
      end
   end

   // The scan carries on while the next word starts below the effective total.
   assign next_row  = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
   assign more_rows = WIDE_W'({next_row, LOG_SW'(0)}) < eff_wide;

   assign found_block = {row_ff, scan_index};

   // Blocks numbered at or beyond the map size are never stored or read.
   assign req_ext    = EXT_W'(req_payload.block_number);
   assign blk_ext    = EXT_W'(blk_ff);
   assign blk_pos    = blk_ext[LOG_SW-1:0];
   assign blk_in_map = CMP_W'(blk_ff) < CMP_W'(MAP_BITS);
   assign blk_bit    = SCAN_WIDTH'(1) << blk_pos;

   assign free_count = (eff_wide > WIDE_W'(used_ff)) ?
                       COUNT_W'(eff_wide - WIDE_W'(used_ff)) : '0;

   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      op_in          = op_ff;
      blk_in         = blk_ff;
      val_in         = val_ff;
      used_in        = used_ff;
      eff_in         = eff_ff;
      res_status_in  = res_status_ff;
      res_block_in   = res_block_ff;
      res_bit_in     = res_bit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = row_ff;
      mem_wr_data    = '0;
      mem_rd_addr    = row_ff;

      if (csr_wr_en) begin
         eff_in = (WIDE_W'(csr_wr_data) > WIDE_W'(MAP_BITS)) ?
                  COUNT_W'(MAP_BITS) : csr_wr_data;
      end

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = row_ff;
            mem_wr_data = '0;
            row_in      = row_ff + ROW_W'(1);
            if (row_ff == ROW_W'(ROWS - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // The first word is read in the same cycle the request is taken.
            if (req_payload.op == OP_ALLOC) begin
               mem_rd_addr = '0;
            end else begin
               mem_rd_addr = req_ext[IDX_W-1:LOG_SW];
            end
            if (req_xfer) begin
               op_in  = req_payload.op;
               blk_in = req_payload.block_number;
               val_in = req_payload.bit_value;
               row_in = '0;
               if (req_payload.op == OP_ALLOC) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_MODIFY;
               end
            end
         end

         ST_SCAN: begin
            // Read the following word ahead so that one word is inspected per cycle.
            mem_rd_addr = row_ff + ROW_W'(1);
            res_bit_in  = 1'b0;
            if (scan_found) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = row_ff;
               mem_wr_data   = mem_rd_data | scan_onehot;
               res_status_in = STATUS_OK;
               res_block_in  = BLOCK_W'(found_block);
               if (used_ff != USED_MAX) begin
                  used_in = used_ff + COUNT_W'(1);
               end
               state_in = ST_RESPOND;
            end else if (more_rows) begin
               row_in = row_ff + ROW_W'(1);
            end else begin
               res_status_in = STATUS_NO_SPACE;
               res_block_in  = '0;
               state_in      = ST_RESPOND;
            end
         end

         ST_MODIFY: begin
            mem_wr_addr   = blk_ext[IDX_W-1:LOG_SW];
            res_status_in = STATUS_OK;
            res_block_in  = blk_ff;
            res_bit_in    = 1'b0;
            unique case (op_ff)
               OP_FREE: begin
                  mem_wr_en   = blk_in_map;
                  mem_wr_data = mem_rd_data & ~blk_bit;
                  if (used_ff != '0) begin
                     used_in = used_ff - COUNT_W'(1);
                  end
               end
               OP_TEST: begin
                  res_bit_in = blk_in_map && mem_rd_data[blk_pos];
               end
               OP_WRITE: begin
                  mem_wr_en   = blk_in_map;
                  mem_wr_data = val_ff ? (mem_rd_data | blk_bit) : (mem_rd_data & ~blk_bit);
               end
               default: begin
                  mem_wr_en = 1'b0;
               end
            endcase
            state_in = ST_RESPOND;
         end

         ST_RESPOND: begin
            // Hold the result until the output register can take it.
            if (rsp_slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.status       = res_status_ff;
               rsp_payload_in.result_block = res_block_ff;
               rsp_payload_in.bit_read     = res_bit_ff;
               rsp_payload_in.free_count   = free_count;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            row_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         used_ff      <= '0;
         eff_ff       <= COUNT_W'(EFF_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         used_ff      <= used_in;
         eff_ff       <= eff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      blk_ff         <= blk_in;
      val_ff         <= val_in;
      res_status_ff  <= res_status_in;
      res_block_ff   <= res_block_in;
      res_bit_ff     <= res_bit_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule
